[src/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// I2C register access master: shared types and constants
// Item layouts, bus phase codes, operation codes and the per-phase lookups
// used by the bus engine and the top level.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Pin step length after reset.
  localparam logic [15:0] STEP_CYCLES_RESET = 16'd250;

  // Bit mask of the first (most significant) bit sent on the wire.
  localparam logic [7:0] MSB_MASK = 8'h80;

  // Bus phases.
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START     = 4'd1,
    PH_ADDRW     = 4'd2,
    PH_ACK_ADDRW = 4'd3,
    PH_REG       = 4'd4,
    PH_ACK_REG   = 4'd5,
    PH_DATA      = 4'd6,
    PH_ACK_DATA  = 4'd7,
    PH_RSTART    = 4'd8,
    PH_ADDRR     = 4'd9,
    PH_ACK_ADDRR = 4'd10,
    PH_RPREP     = 4'd11,
    PH_RBIT      = 4'd12,
    PH_MACK      = 4'd13,
    PH_STOP      = 4'd14
  } phase_t;

  // One input item.
  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       data_request;
    logic [7:0] read_data;
    logic       read_valid;
    logic       done_res;
    logic       nack_error;
  } out_item_t;

  // Number of pin steps making up one pass through a phase.
  function automatic logic [2:0] substeps_of(input phase_t p);
    logic [2:0] n;
    begin
      unique case (p)
        PH_START, PH_RSTART: n = 3'd4;
        PH_ACK_ADDRW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_ADDRR: n = 3'd4;
        PH_RPREP: n = 3'd1;
        default: n = 3'd3;
      endcase
      return n;
    end
  endfunction

  // True for the phases that shift a byte out to the device.
  function automatic logic is_send(input phase_t p);
    return (p == PH_ADDRW) || (p == PH_REG) || (p == PH_DATA) || (p == PH_ADDRR);
  endfunction

endpackage

[src/i2cm_in_stage.sv]
// ----------------------------------------------------------------------------
// I2C register access master: input register
// Holds one accepted item until the bus engine consumes it.
// ----------------------------------------------------------------------------
module i2cm_in_stage
  import i2cm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  input  logic     take,
  output logic     held_valid,
  output in_item_t held_item
);

  logic held_valid_next;
  logic accept;

  // The register is free once its item is taken in the same cycle.
  assign in_stall = held_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    held_valid_next = held_valid;
    if (accept) begin
      held_valid_next = 1'b1;
    end else if (take) begin
      held_valid_next = 1'b0;
    end
  end

  // Valid flag under reset; payload loads on acceptance only.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_item <= in_data;
    end
  end

endmodule

[src/i2cm_engine.sv]
// ----------------------------------------------------------------------------
// I2C register access master: bus engine
// Advances the transaction state by one clock of bus time per item and
// forms the result item of that step.
// ----------------------------------------------------------------------------
module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  in_item_t    item,
  input  logic [15:0] step_cycles,
  output out_item_t   result
);

  phase_t      phase, phase_next;
  logic [1:0]  pin_substep, pin_substep_next;
  logic [15:0] step_timer, step_timer_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [6:0]  target_latch, target_latch_next;
  logic [7:0]  register_latch, register_latch_next;
  logic        is_read, is_read_next;
  logic        error_flag, error_flag_next;
  logic        scl_drive, scl_drive_next;
  logic        sda_drive, sda_drive_next;

  logic [7:0]  mask;
  logic [15:0] step_len;
  logic [16:0] timer_inc;
  logic [2:0]  sub_inc;
  logic [3:0]  bit_inc;
  logic [7:0]  bytes_dec;
  logic        finish;
  logic        dreq;
  logic        rvalid;
  logic        done;
  logic [7:0]  rbyte;

  assign mask      = MSB_MASK >> bit_index[2:0];
  assign step_len  = (step_cycles == 16'd0) ? 16'd1 : step_cycles;
  assign timer_inc = {1'b0, step_timer} + 17'd1;
  assign sub_inc   = {1'b0, pin_substep} + 3'd1;
  assign bit_inc   = bit_index + 4'd1;
  assign bytes_dec = bytes_left - 8'd1;

  // Next state for one clock of bus time: pin action, step timing, phase change.
  always_comb begin
    phase_next          = phase;
    pin_substep_next    = pin_substep;
    step_timer_next     = step_timer;
    bit_index_next      = bit_index;
    shift_byte_next     = shift_byte;
    bytes_left_next     = bytes_left;
    target_latch_next   = target_latch;
    register_latch_next = register_latch;
    is_read_next        = is_read;
    error_flag_next     = error_flag;
    scl_drive_next      = scl_drive;
    sda_drive_next      = sda_drive;
    finish              = 1'b0;
    dreq                = 1'b0;
    rvalid              = 1'b0;
    done                = 1'b0;
    rbyte               = 8'd0;

    if (phase == PH_IDLE) begin
      // A new transaction latches its operands; pins move from the next step.
      if (item.operation == OP_WRITE || item.operation == OP_READ) begin
        target_latch_next   = item.device_address;
        register_latch_next = item.register_address;
        bytes_left_next     = item.byte_count;
        is_read_next        = (item.operation == OP_READ);
        error_flag_next     = 1'b0;
        step_timer_next     = 16'd0;
        phase_next          = PH_START;
        pin_substep_next    = 2'd0;
        bit_index_next      = 4'd0;
      end
    end else begin
      // Pin action at the first cycle of each pin step.
      if (step_timer == 16'd0) begin
        unique case (phase)
          PH_START, PH_RSTART: begin
            unique case (pin_substep)
              2'd0: sda_drive_next = 1'b1;
              2'd1: scl_drive_next = 1'b1;
              2'd2: sda_drive_next = 1'b0;
              default: scl_drive_next = 1'b0;
            endcase
          end
          PH_ADDRW, PH_REG, PH_DATA, PH_ADDRR: begin
            if (pin_substep == 2'd0) begin
              if (phase == PH_DATA && bit_index == 4'd0) begin
                dreq            = 1'b1;
                shift_byte_next = item.write_data;
              end
              sda_drive_next = |(shift_byte_next & mask);
            end else if (pin_substep == 2'd1) begin
              scl_drive_next = 1'b1;
            end else begin
              scl_drive_next = 1'b0;
            end
          end
          PH_ACK_ADDRW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_ADDRR: begin
            unique case (pin_substep)
              2'd0: sda_drive_next = 1'b1;
              2'd1: scl_drive_next = 1'b1;
              2'd2: begin
                if (item.sda_in && (phase == PH_ACK_ADDRW || phase == PH_ACK_DATA)) begin
                  error_flag_next = 1'b1;
                end
              end
              default: scl_drive_next = 1'b0;
            endcase
          end
          PH_RPREP: sda_drive_next = 1'b1;
          PH_RBIT: begin
            if (pin_substep == 2'd0) begin
              scl_drive_next = 1'b1;
            end else if (pin_substep == 2'd1) begin
              if (item.sda_in) begin
                shift_byte_next = shift_byte | mask;
              end
            end else begin
              scl_drive_next = 1'b0;
            end
          end
          PH_MACK: begin
            if (pin_substep == 2'd0) begin
              // The last byte read is answered with a NACK.
              sda_drive_next = (bytes_left == 8'd1);
              rvalid         = 1'b1;
              rbyte          = shift_byte_next;
            end else if (pin_substep == 2'd1) begin
              scl_drive_next = 1'b1;
            end else begin
              scl_drive_next = 1'b0;
            end
          end
          PH_STOP: begin
            if (pin_substep == 2'd0) begin
              sda_drive_next = 1'b0;
            end else if (pin_substep == 2'd1) begin
              scl_drive_next = 1'b1;
            end else begin
              sda_drive_next = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      // Step timing, then substep and bit counting.
      if (timer_inc >= {1'b0, step_len}) begin
        step_timer_next = 16'd0;
        if (sub_inc >= substeps_of(phase)) begin
          pin_substep_next = 2'd0;
          if (phase == PH_RBIT || is_send(phase)) begin
            bit_index_next = bit_inc;
            finish         = bit_inc[3];
          end else begin
            finish = 1'b1;
          end
        end else begin
          pin_substep_next = sub_inc[1:0];
        end
      end else begin
        step_timer_next = timer_inc[15:0];
      end

      // Phase change at the end of a phase.
      if (finish) begin
        pin_substep_next = 2'd0;
        bit_index_next   = 4'd0;
        unique case (phase)
          PH_START: begin
            phase_next      = PH_ADDRW;
            shift_byte_next = {target_latch, 1'b0};
          end
          PH_ADDRW: phase_next = PH_ACK_ADDRW;
          PH_ACK_ADDRW: begin
            if (error_flag_next) begin
              phase_next = PH_STOP;
            end else begin
              phase_next      = PH_REG;
              shift_byte_next = register_latch;
            end
          end
          PH_REG: phase_next = PH_ACK_REG;
          PH_ACK_REG: begin
            if (is_read) begin
              phase_next = PH_RSTART;
            end else if (bytes_left != 8'd0) begin
              phase_next = PH_DATA;
            end else begin
              phase_next = PH_STOP;
            end
          end
          PH_DATA: phase_next = PH_ACK_DATA;
          PH_ACK_DATA: begin
            if (error_flag_next) begin
              phase_next = PH_STOP;
            end else begin
              bytes_left_next = bytes_dec;
              phase_next      = (bytes_dec != 8'd0) ? PH_DATA : PH_STOP;
            end
          end
          PH_RSTART: begin
            phase_next      = PH_ADDRR;
            shift_byte_next = {target_latch, 1'b1};
          end
          PH_ADDRR: phase_next = PH_ACK_ADDRR;
          PH_ACK_ADDRR: phase_next = (bytes_left != 8'd0) ? PH_RPREP : PH_STOP;
          PH_RPREP: begin
            phase_next      = PH_RBIT;
            shift_byte_next = 8'd0;
          end
          PH_RBIT: phase_next = PH_MACK;
          PH_MACK: begin
            bytes_left_next = bytes_dec;
            phase_next      = (bytes_dec != 8'd0) ? PH_RPREP : PH_STOP;
          end
          PH_STOP: begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // Result item of this step.
  always_comb begin
    result.scl_out      = scl_drive_next;
    result.sda_out      = sda_drive_next;
    result.busy_res     = (phase_next != PH_IDLE);
    result.data_request = dreq;
    result.read_data    = rvalid ? rbyte : 8'd0;
    result.read_valid   = rvalid;
    result.done_res     = done;
    result.nack_error   = done && error_flag_next;
  end

  // State registers advance once per consumed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      pin_substep    <= 2'd0;
      step_timer     <= 16'd0;
      bit_index      <= 4'd0;
      shift_byte     <= 8'd0;
      bytes_left     <= 8'd0;
      target_latch   <= 7'd0;
      register_latch <= 8'd0;
      is_read        <= 1'b0;
      error_flag     <= 1'b0;
      scl_drive      <= 1'b1;
      sda_drive      <= 1'b1;
    end else if (step) begin
      phase          <= phase_next;
      pin_substep    <= pin_substep_next;
      step_timer     <= step_timer_next;
      bit_index      <= bit_index_next;
      shift_byte     <= shift_byte_next;
      bytes_left     <= bytes_left_next;
      target_latch   <= target_latch_next;
      register_latch <= register_latch_next;
      is_read        <= is_read_next;
      error_flag     <= error_flag_next;
      scl_drive      <= scl_drive_next;
      sda_drive      <= sda_drive_next;
    end
  end

endmodule

[src/i2cm_out_stage.sv]
// ----------------------------------------------------------------------------
// I2C register access master: result register
// Holds the latest result item until the receiving side takes it.
// ----------------------------------------------------------------------------
module i2cm_out_stage
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t result,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall,
  output logic      free
);

  logic out_valid_next;

  // Room for a new result when empty or when the held one leaves this cycle.
  assign free = !out_valid || !out_stall;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

endmodule

[src/i2c_register_access_master_unit.sv]
// ----------------------------------------------------------------------------
// I2C register access master: top level
// Each input item is one clock of bus time; the engine answers it with one
// result item carrying the line drives and transaction status.
// ----------------------------------------------------------------------------
// One item is taken in every clock cycle while the result side keeps up. The
// item is held in the input register and its result in the result register,
// with the engine update between them. The throughput is set by the single
// state update the engine makes per item. Bus timing is counted in items:
// every pin action is held for cfg step_cycles items (zero counts as one), so
// one bit on the wire takes three or four such steps.
module i2c_register_access_master_unit
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  in_item_t    in_data,
  output logic        in_stall,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        out_stall,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic        held_valid;
  in_item_t    held_item;
  logic        out_free;
  logic        step;
  out_item_t   result;
  logic [15:0] step_cycles;

  // The engine consumes the held item whenever the result register has room.
  assign step      = held_valid && out_free;
  assign cfg_ready = 1'b1;

  // Pin step length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cycles <= STEP_CYCLES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step_cycles <= cfg_data;
    end
  end

  i2cm_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .take       (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  i2cm_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (held_item),
    .step_cycles (step_cycles),
    .result      (result)
  );

  i2cm_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .result    (result),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .free      (out_free)
  );

`ifndef ASSERT_OFF
  // A finished transaction is never reported as still busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.done_res) |-> !out_data.busy_res)
    else $error("done reported while busy");

  // The error flag is only shown together with done.
  a_nack_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.nack_error) |-> out_data.done_res)
    else $error("nack_error without done");

  // Writing and reading never happen in the same step.
  a_req_or_read: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.data_request && out_data.read_valid))
    else $error("data_request and read_valid together");

  // The input side stalls only while an item is held and cannot move on.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (held_valid && out_valid && out_stall))
    else $error("input stalled without cause");
`endif

endmodule
